// File: src/tsop_pkg.sv
`timescale 1ns / 1ps

package tsop_pkg;

	localparam int MAX_OPTION_BYTES = 40;

	localparam logic [7:0] KIND_EOL = 8'd0;
	localparam logic [7:0] KIND_NOP = 8'd1;
	localparam logic [7:0] KIND_TS  = 8'd8;
	localparam logic [7:0] TS_SIZE  = 8'd10;
	localparam logic [7:0] MIN_SIZE = 8'd2;

	// byte offsets inside the timestamp option
	localparam logic [5:0] VAL_OFFSET = 6'd2;
	localparam logic [5:0] ECR_OFFSET = 6'd6;
	localparam logic [5:0] WORD_BYTES = 6'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_CUT    = 2'd1;
	localparam logic [1:0] ST_BADLEN = 2'd2;

	typedef struct packed {
		logic [7:0] opt_byte;
		logic       area_start;
		logic [5:0] area_len;
	} opt_word_t;

	typedef struct packed {
		logic        ts_found;
		logic [31:0] ts_value;
		logic [31:0] ts_echo;
		logic [1:0]  parse_status;
	} ts_result_t;

endpackage

// File: src/tsop_if.sv
`timescale 1ns / 1ps

interface tsop_opt_if;
	import tsop_pkg::*;

	logic      valid;
	logic      ready;
	opt_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tsop_res_if;
	import tsop_pkg::*;

	logic       valid;
	logic       ready;
	ts_result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/tcp_timestamp_option_parser_core.sv
`timescale 1ns / 1ps

// TCP timestamp option parser. Option bytes of a TCP header arrive one per word
// on byte_ch, the first word of an area flagged by area_start and carrying the
// area length (0 gives an empty result at once, above 40 is clipped to 40).
// The walker skips NOP, stops at EOL, skips other options by their length byte
// and captures the first timestamp option of length 10 (value and echo, both
// big-endian). A kind byte with no room for its length, or a length below 2 or
// past the end of the area, is reported in parse_status. One result word leaves
// on result_ch with the last byte of each area. A word is registered on entry,
// walked by a single small state update and the result lands in an output
// register, so a byte is accepted every cycle while the result side keeps up;
// a result passes through the input register and then the output register. A new
// area_start inside an open area drops the old area without a result.

module tcp_timestamp_option_parser_core (
	input  logic      clk,
	input  logic      arst_n,
	tsop_opt_if.sink  byte_ch,
	tsop_res_if.source result_ch
);
	import tsop_pkg::*;

	// walk phases
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_KIND = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_BODY = 3'd3;
	localparam logic [2:0] PH_TS   = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	localparam logic [5:0] MAX_LEN = 6'(MAX_OPTION_BYTES);

	// input register
	logic      valid_s1;
	opt_word_t word_s1;
	logic      advance;

	// walk state
	logic [2:0]  phase_q;
	logic [5:0]  left_q;
	logic        kind_ts_q;   // pending option is a timestamp kind
	logic [5:0]  size_q;
	logic [5:0]  offset_q;
	logic [31:0] value_q;
	logic [31:0] echo_q;
	logic        found_q;
	logic [1:0]  err_q;

	// result register
	logic       res_valid_q;
	ts_result_t res_q;

	// next-state values
	logic [2:0]  phase_d;
	logic [5:0]  left_d;
	logic        kind_ts_d;
	logic [5:0]  size_d;
	logic [5:0]  offset_d;
	logic [31:0] value_d;
	logic [31:0] echo_d;
	logic        found_d;
	logic [1:0]  err_d;
	logic        emit;
	ts_result_t  res_d;

	// stall the walker whenever the result register is occupied and not being taken
	assign advance       = valid_s1 && (!res_valid_q || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;

	assign result_ch.valid = res_valid_q;
	assign result_ch.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			word_s1 <= byte_ch.data;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic [5:0] len;
		logic [5:0] rem;
		logic [5:0] off_inc;
		logic       walk;
		logic       ok;

		b   = word_s1.opt_byte;
		len = (word_s1.area_len > MAX_LEN) ? MAX_LEN : word_s1.area_len;

		phase_d   = phase_q;
		left_d    = left_q;
		kind_ts_d = kind_ts_q;
		size_d    = size_q;
		offset_d  = offset_q;
		value_d   = value_q;
		echo_d    = echo_q;
		found_d   = found_q;
		err_d     = err_q;
		emit      = 1'b0;
		walk      = 1'b0;

		if (word_s1.area_start) begin
			// fresh area: clear everything
			phase_d   = PH_KIND;
			left_d    = len;
			kind_ts_d = 1'b0;
			size_d    = '0;
			offset_d  = '0;
			value_d   = '0;
			echo_d    = '0;
			found_d   = 1'b0;
			err_d     = ST_OK;
			if (len == '0) begin
				phase_d = PH_IDLE;
				emit    = 1'b1;
			end else begin
				walk = 1'b1;
			end
		end else if (phase_q != PH_IDLE && left_q != '0) begin
			walk = 1'b1;
		end

		rem     = left_d;
		off_inc = offset_d + 6'd1;

		if (walk) begin
			unique case (phase_d)
				PH_KIND: begin
					priority if (b == KIND_EOL) begin
						phase_d = PH_DONE;
					end else if (b == KIND_NOP) begin
						phase_d = PH_KIND;
					end else if (rem < 6'd2) begin
						err_d   = ST_CUT;
						phase_d = PH_DONE;
					end else begin
						kind_ts_d = (b == KIND_TS);
						phase_d   = PH_LEN;
					end
				end
				PH_LEN: begin
					// area left at the kind byte was rem + 1
					if (b < MIN_SIZE || {1'b0, b} > ({3'b000, rem} + 9'd1)) begin
						err_d   = ST_BADLEN;
						phase_d = PH_DONE;
					end else begin
						size_d   = b[5:0];
						offset_d = VAL_OFFSET;
						priority if (kind_ts_d && b == TS_SIZE) begin
							phase_d = PH_TS;
						end else if (b == MIN_SIZE) begin
							phase_d = PH_KIND;
						end else begin
							phase_d = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					offset_d = off_inc;
					if (off_inc >= size_d) begin
						phase_d = PH_KIND;
					end
				end
				PH_TS: begin
					if (offset_d < ECR_OFFSET) begin
						value_d = {value_d[23:0], b};
					end else begin
						echo_d = {echo_d[23:0], b};
					end
					offset_d = off_inc;
					if (off_inc >= ECR_OFFSET + WORD_BYTES) begin
						found_d = 1'b1;
						phase_d = PH_DONE;
					end
				end
				default: begin
					// done or idle: byte ignored
				end
			endcase
			left_d = rem - 6'd1;
			if (left_d == '0) begin
				emit    = 1'b1;
				phase_d = PH_IDLE;
			end
		end

		ok                 = found_d && (err_d == ST_OK);
		res_d.ts_found     = ok;
		res_d.ts_value     = ok ? value_d : '0;
		res_d.ts_echo      = ok ? echo_d : '0;
		res_d.parse_status = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			left_q    <= '0;
			kind_ts_q <= 1'b0;
			size_q    <= '0;
			offset_q  <= '0;
			value_q   <= '0;
			echo_q    <= '0;
			found_q   <= 1'b0;
			err_q     <= ST_OK;
		end else if (advance) begin
			phase_q   <= phase_d;
			left_q    <= left_d;
			kind_ts_q <= kind_ts_d;
			size_q    <= size_d;
			offset_q  <= offset_d;
			value_q   <= value_d;
			echo_q    <= echo_d;
			found_q   <= found_d;
			err_q     <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

endmodule

// File: tb/tb_tcp_timestamp_option_parser_core.sv
`timescale 1ns / 1ps

module tb_tcp_timestamp_option_parser_core;
	import tsop_pkg::*;

	typedef enum logic [2:0] {
		WALK_IDLE,
		WALK_KIND,
		WALK_LEN,
		WALK_BODY,
		WALK_TS,
		WALK_DONE
	} walk_phase_e;

	// Tracks the options walk, queues the result each area should give, checks the results.
	class ts_option_tracker;
		walk_phase_e phase;
		logic [5:0]  bytes_left;
		logic [7:0]  kind_byte;
		logic [7:0]  size_byte;
		logic [7:0]  opt_offset;
		logic [31:0] value_acc;
		logic [31:0] echo_acc;
		logic        ts_seen;
		logic [1:0]  status;

		ts_result_t  pending[$];
		int          mismatches;
		int          checked;
		int          found_seen;
		int          errors_seen;

		function new();
			clear_walk();
			phase       = WALK_IDLE;
			mismatches  = 0;
			checked     = 0;
			found_seen  = 0;
			errors_seen = 0;
		endfunction

		function void clear_walk();
			phase      = WALK_IDLE;
			bytes_left = '0;
			kind_byte  = '0;
			size_byte  = '0;
			opt_offset = '0;
			value_acc  = '0;
			echo_acc   = '0;
			ts_seen    = 1'b0;
			status     = ST_OK;
		endfunction

		function void queue_result();
			ts_result_t r;
			logic       ok;
			ok             = ts_seen && (status == ST_OK);
			r.ts_found     = ok;
			r.ts_value     = ok ? value_acc : 32'd0;
			r.ts_echo      = ok ? echo_acc : 32'd0;
			r.parse_status = status;
			pending.push_back(r);
		endfunction

		function void walk_byte(logic [7:0] b);
			case (phase)
				WALK_KIND: begin
					if (b == KIND_EOL) begin
						phase = WALK_DONE;
					end else if (b == KIND_NOP) begin
						// single byte, next is a kind again
					end else if (bytes_left < 6'd2) begin
						status = ST_CUT;
						phase  = WALK_DONE;
					end else begin
						kind_byte = b;
						phase     = WALK_LEN;
					end
				end
				WALK_LEN: begin
					// room at the kind byte was one more than now
					if (b < MIN_SIZE || int'(b) > int'(bytes_left) + 1) begin
						status = ST_BADLEN;
						phase  = WALK_DONE;
					end else begin
						size_byte  = b;
						opt_offset = 8'(VAL_OFFSET);
						if (kind_byte == KIND_TS && b == TS_SIZE)
							phase = WALK_TS;
						else if (b == MIN_SIZE)
							phase = WALK_KIND;
						else
							phase = WALK_BODY;
					end
				end
				WALK_BODY: begin
					opt_offset = opt_offset + 8'd1;
					if (opt_offset >= size_byte)
						phase = WALK_KIND;
				end
				WALK_TS: begin
					if (opt_offset < 8'(ECR_OFFSET))
						value_acc = {value_acc[23:0], b};
					else
						echo_acc = {echo_acc[23:0], b};
					opt_offset = opt_offset + 8'd1;
					if (opt_offset >= 8'(ECR_OFFSET + WORD_BYTES)) begin
						ts_seen = 1'b1;
						phase   = WALK_DONE;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void note_byte(opt_word_t w);
			logic [5:0] len;
			if (w.area_start) begin
				clear_walk();
				len = w.area_len;
				if (len > 6'(MAX_OPTION_BYTES))
					len = 6'(MAX_OPTION_BYTES);
				if (len == 6'd0) begin
					queue_result();
					return;
				end
				bytes_left = len;
				phase      = WALK_KIND;
			end else if (phase == WALK_IDLE || bytes_left == 6'd0) begin
				return;
			end
			walk_byte(w.opt_byte);
			bytes_left = bytes_left - 6'd1;
			if (bytes_left == 6'd0) begin
				queue_result();
				phase = WALK_IDLE;
			end
		endfunction

		function void check_result(ts_result_t got);
			ts_result_t want;
			logic       bad;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: found=%0b value=%08h echo=%08h status=%0d",
						$time, got.ts_found, got.ts_value, got.ts_echo, got.parse_status);
				return;
			end
			want = pending.pop_front();
			if (want.ts_found)
				found_seen++;
			if (want.parse_status != ST_OK)
				errors_seen++;
			bad = (got.ts_found !== want.ts_found) || (got.ts_value !== want.ts_value) ||
				(got.ts_echo !== want.ts_echo) || (got.parse_status !== want.parse_status);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] result mismatch #%0d", $time, mismatches);
					$display("    expected found=%0b value=%08h echo=%08h status=%0d",
						want.ts_found, want.ts_value, want.ts_echo, want.parse_status);
					$display("    actual   found=%0b value=%08h echo=%08h status=%0d",
						got.ts_found, got.ts_value, got.ts_echo, got.parse_status);
				end
			end
		endfunction
	endclass

	// receiver hold-off used once mid-run to back the block up into its input
	localparam int HOLD_CYCLES  = 160;
	localparam int HOLD_AT_WORD = 300;
	localparam int TARGET_WORDS = 700;
	// no idling on either side from here on
	localparam int QUIET_WORD   = 620;

	logic clk;
	logic arst_n;

	tsop_opt_if opt_ch ();
	tsop_res_if res_ch ();

	tcp_timestamp_option_parser_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (opt_ch),
		.result_ch (res_ch)
	);

	ts_option_tracker ts_tracker = new();

	bit quiet_tail;
	bit hold_req;
	bit area_open;	// an abandoned area is still open in the block
	int words_sent;
	int areas_sent;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog. Bounds the slowest legal run (every word after the longest gap,
	// every result behind the longest stall, plus the long hold).
	initial begin
		#4000000;
		$display("tcp_timestamp_option_parser_core verification failed");
		$finish;
	end

	// Results are checked at the rising edge, on the values from before the edge.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			ts_tracker.check_result(res_ch.data);
	end

	// Result side: random stall bursts, one long hold-off when asked, none at the tail.
	initial begin
		int  stall_left;
		bit  held;
		res_ch.ready = 1'b0;
		stall_left   = 0;
		held         = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held         = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall_left   = $urandom_range(1, 17) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// One word to the block. Valid is left high after acceptance so that
	// back-to-back words never see it dropped and raised in the same step.
	task automatic send_byte(input logic [7:0] b, input logic first, input logic [5:0] len);
		opt_word_t w;
		int        gap;
		w.opt_byte   = b;
		w.area_start = first;
		// length only matters on the first word; noise elsewhere
		w.area_len   = first ? len : 6'($urandom_range(0, 63));
		if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			opt_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		opt_ch.valid <= 1'b1;
		opt_ch.data  <= w;
		do @(posedge clk); while (!opt_ch.ready);
		ts_tracker.note_byte(w);
		words_sent++;
		if (words_sent == HOLD_AT_WORD)
			hold_req = 1'b1;
		if (words_sent >= QUIET_WORD)
			quiet_tail = 1'b1;
	endtask

	task automatic send_area(input logic [5:0] len_field, input logic [7:0] body[$]);
		foreach (body[i])
			send_byte(body[i], (i == 0), len_field);
		areas_sent++;
	endtask

	// Well-formed option list of exactly 'room' bytes; a lone trailing kind byte
	// may still be cut off, which is a legal outcome too.
	function automatic void fill_options(input int room, output logic [7:0] q[$]);
		int left;
		int pick;
		int olen;
		q    = {};
		left = room;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				// EOL, then padding that the walk skips
				q.push_back(KIND_EOL);
				left--;
				while (left > 0) begin
					q.push_back(8'($urandom_range(0, 255)));
					left--;
				end
			end else if (pick < 25) begin
				q.push_back(KIND_NOP);
				left--;
			end else if (pick < 60 && left >= 10) begin
				q.push_back(KIND_TS);
				q.push_back(TS_SIZE);
				repeat (8) q.push_back(8'($urandom_range(0, 255)));
				left -= 10;
			end else if (pick < 70 && left >= 2) begin
				// timestamp kind with a length other than ten: plain skip
				olen = $urandom_range(2, (left < 14) ? left : 14);
				if (olen == 10)
					olen = 9;
				q.push_back(KIND_TS);
				q.push_back(8'(olen));
				repeat (olen - 2) q.push_back(8'($urandom_range(0, 255)));
				left -= olen;
			end else if (left >= 2) begin
				olen = $urandom_range(2, (left < 12) ? left : 12);
				q.push_back(8'($urandom_range(2, 255)));
				q.push_back(8'(olen));
				repeat (olen - 2) q.push_back(8'($urandom_range(0, 255)));
				left -= olen;
			end else begin
				q.push_back(8'($urandom_range(2, 255)));
				left--;
			end
		end
	endfunction

	// Mostly well-formed areas with random content; the rest are random byte
	// soup, corrupted lists, abandoned areas, empty areas and stray words.
	task automatic send_random_area();
		logic [7:0] body[$];
		logic [5:0] len_field;
		int         len;
		int         pick;
		int         keep;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			len = ($urandom_range(0, 7) == 0) ? MAX_OPTION_BYTES : $urandom_range(1, 24);
			fill_options(len, body);
			len_field = 6'(len);
			if (len == MAX_OPTION_BYTES && $urandom_range(0, 1) == 1)
				len_field = 6'($urandom_range(MAX_OPTION_BYTES + 1, 63));
			send_area(len_field, body);
			area_open = 1'b0;
		end else if (pick < 78) begin
			len = $urandom_range(1, MAX_OPTION_BYTES);
			repeat (len) body.push_back(8'($urandom_range(0, 255)));
			send_area(6'(len), body);
			area_open = 1'b0;
		end else if (pick < 86) begin
			len = $urandom_range(2, 24);
			fill_options(len, body);
			body[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
			send_area(6'(len), body);
			area_open = 1'b0;
		end else if (pick < 92) begin
			len  = $urandom_range(2, MAX_OPTION_BYTES);
			keep = $urandom_range(1, len - 1);
			fill_options(len, body);
			while (body.size() > keep)
				void'(body.pop_back());
			send_area(6'(len), body);
			area_open = 1'b1;
		end else if (pick < 96 || area_open) begin
			body.push_back(8'($urandom_range(0, 255)));
			send_area(6'd0, body);
			area_open = 1'b0;
		end else begin
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(0, 255)), 1'b0, 6'd0);
		end
	endtask

	initial begin
		logic [7:0] seq[$];

		arst_n       = 1'b0;
		opt_ch.valid = 1'b0;
		opt_ch.data  = '0;
		quiet_tail   = 1'b0;
		hold_req     = 1'b0;
		area_open    = 1'b0;
		words_sent   = 0;
		areas_sent   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// stray word with no area open: dropped
		send_byte(8'hFF, 1'b0, 6'h3F);
		// empty area: immediate all-zero result, byte ignored
		seq = {8'hFF};
		send_area(6'd0, seq);
		// EOL ends the walk, trailing byte ignored
		seq = {KIND_EOL, 8'hAB};
		send_area(6'd2, seq);
		// kind byte on the last position: cut off before its length
		seq = {KIND_TS};
		send_area(6'd1, seq);
		// length byte below the minimum
		seq = {8'h03, 8'h01};
		send_area(6'd2, seq);
		// length byte past the end of the area
		seq = {8'h02, 8'h04, 8'h00};
		send_area(6'd3, seq);
		// area abandoned by a fresh start, no result for it
		seq = {KIND_NOP, KIND_NOP};
		send_area(6'd4, seq);
		// timestamp with extreme value and echo bytes, then a byte after it
		seq = {KIND_NOP, KIND_NOP, KIND_TS, TS_SIZE,
			8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFF};
		send_area(6'd13, seq);

		// --- random part ---
		while (words_sent < TARGET_WORDS)
			send_random_area();

		@(negedge clk);
		opt_ch.valid <= 1'b0;

		// drain, then keep watching to catch any stray extra result
		while (ts_tracker.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d areas in %0d bytes, incl. empty, overlong, abandoned and stray",
			areas_sent, words_sent);
		$display("%0d results checked: %0d with timestamp, %0d with parse error, %0d mismatches",
			ts_tracker.checked, ts_tracker.found_seen, ts_tracker.errors_seen,
			ts_tracker.mismatches);
		if (ts_tracker.mismatches == 0 && ts_tracker.pending.size() == 0) begin
			$display("tcp_timestamp_option_parser_core verification clean");
		end else begin
			$display("tcp_timestamp_option_parser_core verification failed");
		end
		$finish;
	end

endmodule
